>>> rtl/fird_pkg.sv
// ----------------------------------------------------------------------------
// fird_pkg
// Shared types and constants for the recursive FIR deconvolution block.
// ----------------------------------------------------------------------------
package fird_pkg;

  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = 67;
  localparam int IDX_W    = 16;
  localparam int NUM_TAPS = 8;
  localparam int ADDR_W   = 5;
  localparam int CNT_W    = $clog2(DATA_W);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [$clog2(NUM_TAPS)-1:0] reg_idx_t;

  // decimal scale, 1 lsb = 1/10000
  localparam word_t SCALE      = 32'sd10000;
  localparam word_t TAP0_RESET = 32'sd10000;
  localparam word_t SAT_MAX    = 32'sh7fff_ffff;
  localparam word_t SAT_MIN    = 32'sh8000_0000;

  typedef struct packed {
    word_t value;
    logic  fail;
  } div_res_t;

endpackage

>>> rtl/fird_regs.sv
// ----------------------------------------------------------------------------
// fird_regs
// Coefficient register file behind a simple apb-style port.
// ----------------------------------------------------------------------------
module fird_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fird_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [fird_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [fird_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output fird_pkg::word_t             taps [fird_pkg::NUM_TAPS]
);

  fird_pkg::word_t   taps_r [fird_pkg::NUM_TAPS];
  fird_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx        = cfg_paddr[fird_pkg::ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = taps_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r[0] <= fird_pkg::TAP0_RESET;
      for (int i = 1; i < fird_pkg::NUM_TAPS; i++) begin
        taps_r[i] <= '0;
      end
    end else if (wr_en) begin
      taps_r[idx] <= cfg_pwdata;
    end
  end

  always_comb begin
    for (int i = 0; i < fird_pkg::NUM_TAPS; i++) begin
      taps[i] = taps_r[i];
    end
  end

endmodule

>>> rtl/fird_mac.sv
// ----------------------------------------------------------------------------
// fird_mac
// Sequential multiply-accumulate: one tap product per cycle into a 67-bit sum.
// ----------------------------------------------------------------------------
module fird_mac #(
  parameter int TAP_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  fird_pkg::word_t obs,
  input  fird_pkg::word_t taps [TAP_COUNT],
  input  fird_pkg::word_t hist [TAP_COUNT-1],
  output fird_pkg::acc_t  acc,
  output logic            done
);

  localparam int KW = $clog2(TAP_COUNT);
  localparam int HW = (TAP_COUNT > 2) ? $clog2(TAP_COUNT - 1) : 1;

  logic                             busy_r, pv_r, sub_r, last_r, done_r;
  logic [KW-1:0]                    k_r;
  logic [KW-1:0]                    km1;
  logic signed [fird_pkg::PROD_W-1:0] prod_r, prod_nxt;
  fird_pkg::acc_t                   acc_r, ext;
  fird_pkg::word_t                  op_a, op_b;
  logic                             last;

  always_comb begin
    km1  = k_r - KW'(1);
    last = (k_r == KW'(TAP_COUNT - 1));
    // first slot scales the observed sample, the others subtract history terms
    if (k_r == '0) begin
      op_a = obs;
      op_b = fird_pkg::SCALE;
    end else begin
      op_a = taps[k_r];
      op_b = hist[km1[HW-1:0]];
    end
    prod_nxt = op_a * op_b;
    ext      = {{(fird_pkg::ACC_W - fird_pkg::PROD_W){prod_r[fird_pkg::PROD_W-1]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      last_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      pv_r   <= busy_r;
      last_r <= busy_r & last;
      done_r <= pv_r & last_r;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          k_r <= k_r + KW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sub_r  <= (k_r != '0);
    if (start) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= sub_r ? acc_r - ext : acc_r + ext;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

>>> rtl/fird_div.sv
// ----------------------------------------------------------------------------
// fird_div
// Bit-serial restoring divider with round half away from zero and saturation.
// ----------------------------------------------------------------------------
module fird_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  fird_pkg::acc_t     num,
  input  fird_pkg::word_t    den,
  output fird_pkg::div_res_t res,
  output logic               done
);

  localparam int DW = fird_pkg::DATA_W;
  localparam int AW = fird_pkg::ACC_W;
  localparam logic [DW:0] NEG_LIM = (DW + 1)'(1) << (DW - 1);
  localparam logic [DW:0] POS_LIM = NEG_LIM - (DW + 1)'(1);

  typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_ITER, ST_ROUND, ST_SAT} state_t;

  state_t                     state_r;
  logic [AW-1:0]              nabs_r;
  logic [DW-1:0]              dabs_r, rem_r, quo_r;
  logic [DW:0]                q33_r;
  logic [fird_pkg::CNT_W-1:0] cnt_r;
  logic                       neg_r, dz_r, done_r;
  fird_pkg::div_res_t         res_r;

  logic [DW:0] trial, diff, dext, negq;
  logic        ge, half, ovf;
  fird_pkg::acc_t num_neg;
  fird_pkg::word_t den_neg;

  always_comb begin
    num_neg = -num;
    den_neg = -den;
    dext    = {1'b0, dabs_r};
    trial   = {rem_r, quo_r[DW-1]};
    diff    = trial - dext;
    ge      = (trial >= dext);
    half    = ({rem_r, 1'b0} >= dext);
    // quotient reaches 2^32 when the upper part alone covers the divisor
    ovf     = (nabs_r[AW-1:DW] >= {{(AW - 2 * DW){1'b0}}, dabs_r});
    negq    = -q33_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      // early exit on a zero divisor or an overflow, else after the final step
      done_r <= (state_r == ST_SAT) | ((state_r == ST_CHECK) & (dz_r | ovf));
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            nabs_r  <= num[AW-1] ? num_neg : num;
            dabs_r  <= den[DW-1] ? den_neg : den;
            neg_r   <= num[AW-1] ^ den[DW-1];
            dz_r    <= (den == '0);
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (dz_r) begin
            res_r   <= '{value: '0, fail: 1'b1};
            state_r <= ST_IDLE;
          end else if (ovf) begin
            res_r   <= '{value: neg_r ? fird_pkg::SAT_MIN : fird_pkg::SAT_MAX, fail: neg_r};
            state_r <= ST_IDLE;
          end else begin
            rem_r   <= nabs_r[2*DW-1:DW];
            quo_r   <= nabs_r[DW-1:0];
            cnt_r   <= '1;
            state_r <= ST_ITER;
          end
        end
        ST_ITER: begin
          rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
          quo_r <= {quo_r[DW-2:0], ge};
          cnt_r <= cnt_r - fird_pkg::CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          q33_r   <= {1'b0, quo_r} + (DW + 1)'(half);
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          if (neg_r) begin
            res_r.value <= (q33_r > NEG_LIM) ? fird_pkg::SAT_MIN : negq[DW-1:0];
            res_r.fail  <= (q33_r != '0);
          end else begin
            res_r.value <= (q33_r > POS_LIM) ? fird_pkg::SAT_MAX : q33_r[DW-1:0];
            res_r.fail  <= 1'b0;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

>>> rtl/fir_deconvolution.sv
// ----------------------------------------------------------------------------
// fir_deconvolution
// Recovers the input of a known fir filter from its output samples.
// ----------------------------------------------------------------------------
// Each input beat carries one filter output sample y (signed, 1/10000 units)
// and returns one beat with x = round((10000*y - sum h_i*x_(t-i)) / h0),
// rounded half away from zero and saturated to 32 bits, with its position in
// the sequence and a sticky failure flag. Items are handled one at a time:
// each item runs one multiply-accumulate step per tap followed by the 32
// single-bit steps of the restoring divider; a zero h0 or an out-of-range
// quotient ends the division early. A finished result waits in the output
// register while the next item is already taken in. Coefficients tap0..tap7
// sit at byte addresses 0x00..0x1c; write them only while the block is idle.
// ----------------------------------------------------------------------------
module fir_deconvolution #(
  parameter int TAP_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: [31:0] observed_sample
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,
  // in_tuser: [0] first_sample
  input  logic [0:0]                  in_tuser,
  // out_tdata: [31:0] recovered_sample, [47:32] sample_index
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [47:0]                 out_tdata,
  // out_tuser: [0] no_solution
  output logic [0:0]                  out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fird_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [fird_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [fird_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int HL = TAP_COUNT - 1;

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DIV, ST_OUT} state_t;

  state_t                     state_r;
  fird_pkg::word_t            taps_all [fird_pkg::NUM_TAPS];
  fird_pkg::word_t            taps_used [TAP_COUNT];
  fird_pkg::word_t            hist_r [HL];
  fird_pkg::word_t            obs_r;
  logic [fird_pkg::IDX_W-1:0] count_r;
  logic                       fail_r;
  logic                       out_valid_r;
  logic [47:0]                out_data_r;
  logic                       out_flag_r;

  fird_pkg::acc_t     acc;
  fird_pkg::div_res_t res;
  logic               mac_done, div_done, in_fire, slot_free, fail_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign slot_free = ~out_valid_r | out_tready;
  assign fail_nxt  = fail_r | res.fail;

  always_comb begin
    for (int i = 0; i < TAP_COUNT; i++) begin
      taps_used[i] = taps_all[i];
    end
  end

  fird_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .taps        (taps_all)
  );

  fird_mac #(
    .TAP_COUNT (TAP_COUNT)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .obs   (obs_r),
    .taps  (taps_used),
    .hist  (hist_r),
    .acc   (acc),
    .done  (mac_done)
  );

  fird_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_done),
    .num   (acc),
    .den   (taps_all[0]),
    .res   (res),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      fail_r      <= 1'b0;
      for (int i = 0; i < HL; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if ((state_r == ST_OUT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            obs_r <= in_tdata;
            // new sequence clears history before this sample is used
            if (in_tuser[0]) begin
              count_r <= '0;
              fail_r  <= 1'b0;
              for (int i = 0; i < HL; i++) begin
                hist_r[i] <= '0;
              end
            end
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (mac_done) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            out_data_r  <= {count_r, res.value};
            out_flag_r  <= fail_nxt;
            fail_r      <= fail_nxt;
            if (count_r != '1) begin
              count_r <= count_r + fird_pkg::IDX_W'(1);
            end
            hist_r[0] <= res.value;
            for (int i = 1; i < HL; i++) begin
              hist_r[i] <= hist_r[i-1];
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

endmodule

>>> tb/fir_deconvolution_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_deconvolution_checker
// Monitors the sample, result and register ports of the deconvolution block.
// It keeps its own copy of the coefficients, the recovered history, the
// position and the failure flag. Every accepted sample is turned into the
// expected result beat, and each result beat is checked in order against it.
// ----------------------------------------------------------------------------
module fir_deconvolution_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [31:0]                 in_tdata,
  input  logic [0:0]                  in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [47:0]                 out_tdata,
  input  logic [0:0]                  out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [fird_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [fird_pkg::DATA_W-1:0] cfg_pwdata,
  output int                          pending_results,
  output int                          mismatch_count
);

  localparam int HIST_DEPTH = fird_pkg::NUM_TAPS - 1;

  typedef struct packed {
    fird_pkg::word_t            sample;
    logic [fird_pkg::IDX_W-1:0] index;
    logic                       no_solution;
  } recovery_t;

  fird_pkg::word_t            coef [fird_pkg::NUM_TAPS];
  fird_pkg::word_t            recent [HIST_DEPTH];
  logic [fird_pkg::IDX_W-1:0] position;
  logic                       failed;
  recovery_t                  recovery_q [$];
  recovery_t                  want;
  int                         result_beats;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // x = round((10000*y - sum h_k*x_(t-k)) / h0), half away from zero, saturated
  function automatic recovery_t recover_sample(input fird_pkg::word_t y, input logic first);
    logic signed [127:0] num;
    logic signed [127:0] lhs;
    logic signed [127:0] rhs;
    logic [127:0]        mag_num;
    logic [127:0]        mag_den;
    logic [127:0]        quo;
    logic [127:0]        rem;
    logic                neg;
    fird_pkg::word_t     x;
    recovery_t           res;
    if (first) begin
      foreach (recent[k]) recent[k] = '0;
      position = '0;
      failed   = 1'b0;
    end
    lhs = y;
    rhs = fird_pkg::SCALE;
    num = lhs * rhs;
    for (int k = 1; k < fird_pkg::NUM_TAPS; k++) begin
      lhs = coef[k];
      rhs = recent[k-1];
      num = num - lhs * rhs;
    end
    if (coef[0] == '0) begin
      x      = '0;
      failed = 1'b1;
    end else begin
      rhs     = coef[0];
      neg     = num[127] ^ rhs[127];
      mag_num = num[127] ? -num : num;
      mag_den = rhs[127] ? -rhs : rhs;
      quo     = mag_num / mag_den;
      rem     = mag_num % mag_den;
      if ((rem << 1) >= mag_den) quo = quo + 1;
      if (neg) begin
        if (quo > 128'd2147483648) begin
          x = fird_pkg::SAT_MIN;
        end else begin
          quo = -quo;
          x   = quo[31:0];
        end
      end else begin
        x = (quo > 128'd2147483647) ? fird_pkg::SAT_MAX : quo[31:0];
      end
      // a value that rounds to zero does not count as negative
      if (x < 0) failed = 1'b1;
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = x;
    res.sample      = x;
    res.index       = position;
    res.no_solution = failed;
    if (position != '1) position = position + 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (coef[k]) coef[k] = '0;
      coef[0] = fird_pkg::TAP0_RESET;
      foreach (recent[k]) recent[k] = '0;
      position = '0;
      failed   = 1'b0;
      recovery_q.delete();
      result_beats   = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        coef[cfg_paddr[fird_pkg::ADDR_W-1:2]] = cfg_pwdata;
      end
      if (out_tvalid && out_tready) begin
        if (recovery_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected", result_beats));
        end else begin
          want = recovery_q.pop_front();
          if (out_tdata[31:0] !== want.sample) begin
            report_mismatch($sformatf("beat %0d recovered_sample got %0d expected %0d",
                                      result_beats, $signed(out_tdata[31:0]), want.sample));
          end
          if (out_tdata[47:32] !== want.index) begin
            report_mismatch($sformatf("beat %0d sample_index got %0d expected %0d",
                                      result_beats, out_tdata[47:32], want.index));
          end
          if (out_tuser[0] !== want.no_solution) begin
            report_mismatch($sformatf("beat %0d no_solution got %b expected %b",
                                      result_beats, out_tuser[0], want.no_solution));
          end
        end
        result_beats++;
      end
      if (in_tvalid && in_tready) begin
        recovery_q.push_back(recover_sample(in_tdata, in_tuser[0]));
      end
    end
    pending_results <= recovery_q.size();
  end

endmodule

>>> tb/fir_deconvolution_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_deconvolution_tb
// Feeds filter output samples and coefficient writes into the deconvolution
// block: a directed part for unity gain, rounding, zero and extreme leading
// taps and saturation, then randomized phases of filtered sequences and noise
// with random idle cycles on both streams. The checker scores every beat.
// ----------------------------------------------------------------------------
module fir_deconvolution_tb;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 10;
  localparam int PHASE_ITEMS  = 64;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 100;
  localparam int REG_STRIDE   = 4;
  // allows for one item's processing, the long receiver hold and random gaps, with margin
  localparam int QUIET_LIMIT  = 5000;

  typedef enum int { COEF_REALISTIC, COEF_FULL, COEF_SPARSE, COEF_EXTREME } coef_mode_t;
  typedef fird_pkg::word_t coef_set_t [fird_pkg::NUM_TAPS];

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_tvalid   = 1'b0;
  logic                        in_tready;
  logic [31:0]                 in_tdata    = '0;
  logic [0:0]                  in_tuser    = '0;
  logic                        out_tvalid;
  logic                        out_tready  = 1'b0;
  logic [47:0]                 out_tdata;
  logic [0:0]                  out_tuser;
  logic                        cfg_psel    = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite  = 1'b0;
  logic [fird_pkg::ADDR_W-1:0] cfg_paddr   = '0;
  logic [fird_pkg::DATA_W-1:0] cfg_pwdata  = '0;
  logic [fird_pkg::DATA_W-1:0] cfg_prdata;
  logic                        cfg_pready;

  int              pending_results;
  int              mismatch_count;
  int              send_idle_pct   = 0;
  int              recv_idle_pct   = 0;
  int              holds_requested = 0;
  int              holds_done      = 0;
  int              quiet_cycles    = 0;
  coef_set_t       taps;
  fird_pkg::word_t src_hist [fird_pkg::NUM_TAPS-1];

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  fir_deconvolution u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  fir_deconvolution_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  // result side: random stalls, or one long hold when the stimulus asks for it
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (holds_done != holds_requested) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input fird_pkg::word_t y, input bit first);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= y;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_tap(input int idx, input fird_pkg::word_t val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= fird_pkg::ADDR_W'(idx * REG_STRIDE);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering samples and wait until every result beat is back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic load_taps(input coef_set_t c);
    settle();
    for (int k = 0; k < fird_pkg::NUM_TAPS; k++) write_tap(k, c[k]);
    taps = c;
  endtask

  // runs x through the programmed filter, so recovery tracks a real signal
  function automatic fird_pkg::word_t filter_forward(input fird_pkg::word_t x, input bit first);
    longint acc;
    if (first) begin
      foreach (src_hist[k]) src_hist[k] = '0;
    end
    acc = longint'(taps[0]) * longint'(x);
    for (int k = 1; k < fird_pkg::NUM_TAPS; k++) begin
      acc += longint'(taps[k]) * longint'(src_hist[k-1]);
    end
    for (int k = fird_pkg::NUM_TAPS - 2; k > 0; k--) src_hist[k] = src_hist[k-1];
    src_hist[0] = x;
    acc = acc / 10000;
    if (acc > longint'(fird_pkg::SAT_MAX)) return fird_pkg::SAT_MAX;
    if (acc < longint'(fird_pkg::SAT_MIN)) return fird_pkg::SAT_MIN;
    return fird_pkg::word_t'(acc);
  endfunction

  function automatic fird_pkg::word_t random_coef(input coef_mode_t mode, input bit lead);
    case (mode)
      COEF_REALISTIC: begin
        if (lead) return fird_pkg::word_t'($urandom_range(20000, 5000));
        return fird_pkg::word_t'(int'($urandom_range(6000)) - 3000);
      end
      COEF_FULL: return fird_pkg::word_t'($urandom());
      COEF_SPARSE: begin
        if ($urandom_range(3) == 0) return '0;
        return fird_pkg::word_t'(int'($urandom_range(40000)) - 20000);
      end
      default: begin
        case ($urandom_range(5))
          0:       return fird_pkg::SAT_MIN;
          1:       return fird_pkg::SAT_MAX;
          2:       return '0;
          3:       return fird_pkg::word_t'(1);
          4:       return fird_pkg::word_t'(-1);
          default: return fird_pkg::SCALE;
        endcase
      end
    endcase
  endfunction

  function automatic fird_pkg::word_t random_observed();
    case ($urandom_range(9))
      0, 1, 2, 3: return fird_pkg::word_t'($urandom());
      4, 5:       return fird_pkg::word_t'(int'($urandom_range(2000)) - 1000);
      6, 7:       return fird_pkg::word_t'($urandom_range(2000000));
      8:          return fird_pkg::SAT_MAX;
      default:    return fird_pkg::SAT_MIN;
    endcase
  endfunction

  task automatic run_phase(input coef_mode_t mode, input int send_pct, input int recv_pct,
                           input bit long_hold, input bit drain_pause);
    coef_set_t c;
    int        sent;
    int        len;
    bit        held;
    bit        paused;
    for (int k = 0; k < fird_pkg::NUM_TAPS; k++) c[k] = random_coef(mode, k == 0);
    load_taps(c);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (sent < PHASE_ITEMS) begin
      // receiver stops for a long stretch while samples keep coming
      if (long_hold && !held && sent >= 10) begin
        holds_requested++;
        held = 1'b1;
      end
      if (drain_pause && !paused && sent >= PHASE_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        paused = 1'b1;
      end
      if ($urandom_range(99) < 70) begin
        len = $urandom_range(40, 4);
        for (int j = 0; j < len; j++) begin
          send_sample(filter_forward(fird_pkg::word_t'($urandom_range(100000)), j == 0),
                      j == 0);
        end
        sent += len;
      end else begin
        send_sample(random_observed(), $urandom_range(99) < 10);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    coef_set_t c;
    foreach (src_hist[k]) src_hist[k] = '0;
    foreach (taps[k]) taps[k] = '0;
    taps[0] = fird_pkg::TAP0_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients give unity gain; first beat has no sequence start
    send_sample(32'sd1234, 1'b0);
    send_sample('0, 1'b1);
    send_sample(fird_pkg::SAT_MAX, 1'b0);
    send_sample(fird_pkg::SAT_MIN, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(-32'sd1, 1'b1);

    // halves round away from zero, then a run that fills every history tap
    c = '{20000, 5000, -2500, 1000, -1000, 300, -300, 7};
    load_taps(c);
    send_sample(32'sd1, 1'b1);
    send_sample(-32'sd1, 1'b1);
    for (int j = 1; j <= 8; j++) send_sample(fird_pkg::word_t'(j * 100), j == 1);

    // zero leading tap
    c = '{0, 1, 2, 3, 4, 5, 6, 7};
    load_taps(c);
    send_sample(32'sd500, 1'b1);
    send_sample(32'sd100, 1'b0);

    // tiny leading tap drives the quotient out of range both ways
    c = '{1, 0, 0, 0, 0, 0, 0, 0};
    load_taps(c);
    send_sample(32'sd1000000, 1'b1);
    send_sample(-32'sd1000000, 1'b1);

    c = '{-1, 0, 0, 0, 0, 0, 0, 0};
    load_taps(c);
    send_sample(32'sd1, 1'b1);

    c = '{fird_pkg::SAT_MIN, fird_pkg::SAT_MAX, fird_pkg::SAT_MAX, fird_pkg::SAT_MAX,
          fird_pkg::SAT_MAX, fird_pkg::SAT_MAX, fird_pkg::SAT_MAX, fird_pkg::SAT_MAX};
    load_taps(c);
    send_sample(fird_pkg::SAT_MAX, 1'b1);
    send_sample(fird_pkg::SAT_MIN, 1'b0);
    send_sample(32'sd12345, 1'b0);

    run_phase(COEF_REALISTIC, 0, 0, 1'b0, 1'b0);
    run_phase(COEF_REALISTIC, 69, 0, 1'b0, 1'b0);
    run_phase(COEF_REALISTIC, 0, 69, 1'b1, 1'b0);
    run_phase(COEF_REALISTIC, 38, 38, 1'b0, 1'b1);
    run_phase(COEF_FULL, 0, 0, 1'b1, 1'b0);
    run_phase(COEF_SPARSE, 38, 38, 1'b0, 1'b0);
    run_phase(COEF_EXTREME, 0, 69, 1'b0, 1'b1);
    run_phase(COEF_REALISTIC, 69, 0, 1'b0, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
